@@ rtl/u16550_pkg.sv @@
// ----------------------------------------------------------------------------
// u16550_pkg
// Shared constants for the 16550-style UART register model: request kinds,
// register offsets, interrupt identification codes and reset values.
// ----------------------------------------------------------------------------
package u16550_pkg;

    localparam int DEF_RX_DEPTH = 16;

    // Request kinds
    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_RXB   = 2'd2;

    // Register offsets
    localparam logic [2:0] ADDR_DATA = 3'd0;
    localparam logic [2:0] ADDR_IER  = 3'd1;
    localparam logic [2:0] ADDR_IIR  = 3'd2;
    localparam logic [2:0] ADDR_LCR  = 3'd3;
    localparam logic [2:0] ADDR_MCR  = 3'd4;
    localparam logic [2:0] ADDR_LSR  = 3'd5;
    localparam logic [2:0] ADDR_MSR  = 3'd6;
    localparam logic [2:0] ADDR_SCR  = 3'd7;

    // Interrupt identification codes
    localparam logic [3:0] IID_LINE   = 4'h6;
    localparam logic [3:0] IID_RXDATA = 4'h4;
    localparam logic [3:0] IID_TIMEO  = 4'hC;
    localparam logic [3:0] IID_THRE   = 4'h2;
    localparam logic [3:0] IID_MODEM  = 4'h0;
    localparam logic [3:0] IID_NONE   = 4'h1;

    // Trigger levels
    localparam logic [3:0] TRIG_1  = 4'd1;
    localparam logic [3:0] TRIG_4  = 4'd4;
    localparam logic [3:0] TRIG_8  = 4'd8;
    localparam logic [3:0] TRIG_14 = 4'd14;

    localparam logic [7:0] MSR_RESET = 8'hB0;
    localparam logic [7:0] LSR_IDLE  = 8'h60;
    localparam logic [7:0] IIR_FIFO  = 8'hC0;

    // Interrupt identification by standard priority.
    function automatic logic [3:0] irq_id(
        input logic [3:0] ier,
        input logic       ovr,
        input logic       has_data,
        input logic       fifo_en,
        input logic       at_trigger,
        input logic       thre_pend,
        input logic [3:0] msr_delta
    );
        logic [3:0] id;
        id = IID_NONE;
        if (ier[2] && ovr)
        begin
            id = IID_LINE;
        end
        else if (ier[0] && has_data)
        begin
            id = (!fifo_en || at_trigger) ? IID_RXDATA : IID_TIMEO;
        end
        else if (ier[1] && thre_pend)
        begin
            id = IID_THRE;
        end
        else if (ier[3] && (msr_delta != 4'h0))
        begin
            id = IID_MODEM;
        end
        return id;
    endfunction

endpackage

@@ rtl/uart_16550_register_model_unit.sv @@
// ----------------------------------------------------------------------------
// uart_16550_register_model_unit
// Register side of a 16550-style UART: bus reads and writes, received wire
// bytes, receive FIFO in a synchronous memory, and a level interrupt.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake           | Payload
//  ---------+---------------------+-----------------------------------------
//  request  | in_valid / in_stall | req_type, reg_addr, data_byte, burst_last
//  result   | out_valid/out_stall | read_data, rx_accepted, tx_valid,
//           |                     | tx_byte, irq_out
//
//  One request is taken per cycle unless the result stalls; its result is in
//  the output register in the cycle after acceptance. An RBR read addresses the
//  receive memory at acceptance; its registered read data is the result's
//  read_data. A stalled result holds the input stalled too, so that data stays
//  put. Reset sets all control registers to reset values; the receive memory
//  is not cleared and needs no sweep.
module uart_16550_register_model_unit
    import u16550_pkg::*;
#(
    parameter int RX_DEPTH = DEF_RX_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] req_type,
    input  logic [2:0] reg_addr,
    input  logic [7:0] data_byte,
    input  logic       burst_last,

    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] read_data,
    output logic       rx_accepted,
    output logic       tx_valid,
    output logic [7:0] tx_byte,
    output logic       irq_out
);

    localparam int PW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int CW = $clog2(RX_DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(RX_DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(RX_DEPTH);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);

    // Receive memory
    logic [7:0] rx_mem [RX_DEPTH];
    logic [7:0] mem_q;

    // Architectural registers
    logic [7:0]    dll_reg, dll_next;
    logic [7:0]    dlm_reg, dlm_next;
    logic [3:0]    ier_reg, ier_next;
    logic [7:0]    lcr_reg, lcr_next;
    logic [4:0]    mcr_reg, mcr_next;
    logic [7:0]    msr_reg, msr_next;
    logic [7:0]    scr_reg, scr_next;
    logic          ovr_reg, ovr_next;
    logic          fifo_reg, fifo_next;
    logic [3:0]    trig_reg, trig_next;
    logic          thre_reg, thre_next;
    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    // Output register
    logic       ovalid_reg;
    logic       pop_sel_reg;
    logic [7:0] rdata_reg;
    logic       rxacc_reg;
    logic       txv_reg;
    logic [7:0] txb_reg;
    logic       irq_reg;

    logic       accept;
    logic       dlab;
    logic       do_pop;
    logic       do_push;
    logic       push_req;
    logic       full;
    logic [3:0] id_now;
    logic [3:0] id_after;
    logic [7:0] rd_val;
    logic       rxacc_val;
    logic       txv_val;
    logic [7:0] txb_val;
    logic [7:0] msr_new;
    logic [3:0] msr_delta;
    logic       fcr_clear;

    assign in_stall = ovalid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign dlab     = lcr_reg[7];
    assign full     = fifo_reg ? (cnt_reg >= CNT_FULL) : (cnt_reg >= CNT_ONE);

    assign id_now = irq_id(ier_reg, ovr_reg, cnt_reg != '0, fifo_reg,
                           9'(cnt_reg) >= 9'(trig_reg), thre_reg, msr_reg[3:0]);

    // Loopback modem status and its delta bits for an MCR write.
    always_comb
    begin
        if (!data_byte[4])
        begin
            msr_new = MSR_RESET;
        end
        else
        begin
            msr_new = {data_byte[3], data_byte[2], data_byte[0], data_byte[1], 4'h0};
        end
        msr_delta = msr_reg[3:0];
        if (msr_reg[4] != msr_new[4]) msr_delta[0] = 1'b1;
        if (msr_reg[5] != msr_new[5]) msr_delta[1] = 1'b1;
        if (msr_reg[6] && !msr_new[6]) msr_delta[2] = 1'b1;
        if (msr_reg[7] != msr_new[7]) msr_delta[3] = 1'b1;
    end

    always_comb
    begin
        dll_next  = dll_reg;
        dlm_next  = dlm_reg;
        ier_next  = ier_reg;
        lcr_next  = lcr_reg;
        mcr_next  = mcr_reg;
        msr_next  = msr_reg;
        scr_next  = scr_reg;
        ovr_next  = ovr_reg;
        fifo_next = fifo_reg;
        trig_next = trig_reg;
        thre_next = thre_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        do_pop    = 1'b0;
        push_req  = 1'b0;
        rd_val    = 8'h00;
        txv_val   = 1'b0;
        txb_val   = 8'h00;
        fcr_clear = 1'b0;

        case (req_type)
            REQ_READ:
            begin
                unique case (reg_addr)
                    ADDR_DATA:
                    begin
                        if (dlab)
                        begin
                            rd_val = dll_reg;
                        end
                        else
                        begin
                            do_pop = (cnt_reg != '0);
                        end
                    end
                    ADDR_IER: rd_val = dlab ? dlm_reg : {4'h0, ier_reg};
                    ADDR_IIR:
                    begin
                        if (id_now == IID_THRE)
                        begin
                            thre_next = 1'b0;
                        end
                        rd_val = {4'h0, id_now} | (fifo_reg ? IIR_FIFO : 8'h00);
                    end
                    ADDR_LCR: rd_val = lcr_reg;
                    ADDR_MCR: rd_val = {3'b000, mcr_reg};
                    ADDR_LSR:
                    begin
                        rd_val = LSR_IDLE | {ovr_reg && fifo_reg, 5'b00000,
                                             ovr_reg, cnt_reg != '0};
                        ovr_next = 1'b0;
                    end
                    ADDR_MSR:
                    begin
                        rd_val   = msr_reg;
                        msr_next = {msr_reg[7:4], 4'h0};
                    end
                    ADDR_SCR: rd_val = scr_reg;
                    default: rd_val = 8'h00;
                endcase
            end
            REQ_WRITE:
            begin
                unique case (reg_addr)
                    ADDR_DATA:
                    begin
                        if (dlab)
                        begin
                            dll_next = data_byte;
                        end
                        else
                        begin
                            if (mcr_reg[4])
                            begin
                                push_req = 1'b1;
                            end
                            else
                            begin
                                txv_val = 1'b1;
                                txb_val = data_byte;
                            end
                            thre_next = ier_reg[1];
                        end
                    end
                    ADDR_IER:
                    begin
                        if (dlab)
                        begin
                            dlm_next = data_byte;
                        end
                        else
                        begin
                            ier_next = data_byte[3:0];
                            if (!data_byte[1])
                            begin
                                thre_next = 1'b0;
                            end
                            else if (!ier_reg[1])
                            begin
                                thre_next = 1'b1;
                            end
                        end
                    end
                    ADDR_IIR:
                    begin
                        fifo_next = data_byte[0];
                        case (data_byte[7:6])
                            2'b01:   trig_next = TRIG_4;
                            2'b10:   trig_next = TRIG_8;
                            2'b11:   trig_next = TRIG_14;
                            default: trig_next = TRIG_1;
                        endcase
                        fcr_clear = data_byte[1] || (fifo_reg && !data_byte[0]);
                        if (data_byte[2] && ier_reg[1])
                        begin
                            thre_next = 1'b1;
                        end
                    end
                    ADDR_LCR: lcr_next = data_byte;
                    ADDR_MCR:
                    begin
                        mcr_next = data_byte[4:0];
                        msr_next = {msr_new[7:4], msr_delta};
                    end
                    ADDR_SCR: scr_next = data_byte;
                    default: ;
                endcase
            end
            REQ_RXB: push_req = 1'b1;
            default: ;
        endcase

        do_push   = push_req && !full;
        rxacc_val = do_push;
        if (push_req && full)
        begin
            ovr_next = 1'b1;
        end

        if (do_push)
        begin
            tail_next = (tail_reg == PTR_LAST) ? '0 : tail_reg + PW'(1);
            cnt_next  = cnt_reg + CW'(1);
        end
        if (do_pop)
        begin
            head_next = (head_reg == PTR_LAST) ? '0 : head_reg + PW'(1);
            cnt_next  = cnt_reg - CW'(1);
        end
        if (fcr_clear)
        begin
            head_next = '0;
            tail_next = '0;
            cnt_next  = '0;
            ovr_next  = 1'b0;
        end

        id_after = irq_id(ier_next, ovr_next, cnt_next != '0, fifo_next,
                          9'(cnt_next) >= 9'(trig_next), thre_next, msr_next[3:0]);
    end

    // Receive memory: one write at the tail, one registered read at the head.
    always_ff @(posedge clk)
    begin
        if (accept && do_push)
        begin
            rx_mem[tail_reg] <= data_byte;
        end
        if (accept && do_pop)
        begin
            mem_q <= rx_mem[head_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dll_reg    <= 8'd1;
            dlm_reg    <= 8'd0;
            ier_reg    <= 4'h0;
            lcr_reg    <= 8'h00;
            mcr_reg    <= 5'h00;
            msr_reg    <= MSR_RESET;
            scr_reg    <= 8'h00;
            ovr_reg    <= 1'b0;
            fifo_reg   <= 1'b0;
            trig_reg   <= TRIG_1;
            thre_reg   <= 1'b0;
            head_reg   <= '0;
            tail_reg   <= '0;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
            irq_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                dll_reg  <= dll_next;
                dlm_reg  <= dlm_next;
                ier_reg  <= ier_next;
                lcr_reg  <= lcr_next;
                mcr_reg  <= mcr_next;
                msr_reg  <= msr_next;
                scr_reg  <= scr_next;
                ovr_reg  <= ovr_next;
                fifo_reg <= fifo_next;
                trig_reg <= trig_next;
                thre_reg <= thre_next;
                head_reg <= head_next;
                tail_reg <= tail_next;
                cnt_reg  <= cnt_next;
                irq_reg  <= (id_after != IID_NONE);
            end
            if (accept)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    // Result payload; burst_last carries no behavior.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pop_sel_reg <= do_pop;
            rdata_reg   <= rd_val;
            rxacc_reg   <= rxacc_val;
            txv_reg     <= txv_val;
            txb_reg     <= txb_val;
        end
    end

    assign out_valid   = ovalid_reg;
    assign read_data   = pop_sel_reg ? mem_q : rdata_reg;
    assign rx_accepted = rxacc_reg;
    assign tx_valid    = txv_reg;
    assign tx_byte     = txb_reg;
    assign irq_out     = irq_reg;

endmodule

@@ verif/tb_uart_16550_register_model_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_uart_16550_register_model_unit
// Self-checking bench for the 16550-style UART register block. Register
// reads and writes, wire bytes and unused request codes are driven with
// random gaps on the request side and random stalls on the result side. A
// scoreboard class keeps its own copy of the UART registers and receive FIFO,
// predicts each result when its request is accepted, and compares every
// returned result field by field in order.
// ----------------------------------------------------------------------------
module tb_uart_16550_register_model_unit;

    import u16550_pkg::*;

    localparam logic [1:0] REQ_NONE    = 2'd3;
    localparam int         ITEM_TARGET = 1450;
    localparam int         SEGMENT     = 200;

    typedef struct packed {
        logic [7:0] read_data;
        logic       rx_accepted;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       irq_out;
    } uart_result_t;

    class uart_scoreboard;
        logic [7:0]   dll;
        logic [7:0]   dlm;
        logic [3:0]   ier;
        logic [7:0]   lcr;
        logic [4:0]   mcr;
        logic [7:0]   msr;
        logic [7:0]   scr;
        logic         ovr;
        logic         fifo_en;
        logic [3:0]   trig;
        logic         thre_pend;
        logic [7:0]   rx_mem [DEF_RX_DEPTH];
        logic [3:0]   rx_head;
        logic [3:0]   rx_tail;
        logic [4:0]   rx_cnt;
        uart_result_t awaited_q [$];
        int           errors;

        function new();
            dll       = 8'h01;
            dlm       = 8'h00;
            ier       = 4'h0;
            lcr       = 8'h00;
            mcr       = 5'h00;
            msr       = MSR_RESET;
            scr       = 8'h00;
            ovr       = 1'b0;
            fifo_en   = 1'b0;
            trig      = TRIG_1;
            thre_pend = 1'b0;
            rx_head   = '0;
            rx_tail   = '0;
            rx_cnt    = '0;
            errors    = 0;
        endfunction

        task report(input string msg);
            $display("ERROR at %0t ns: %s", $time, msg);
            errors++;
        endtask

        function logic rx_push(input logic [7:0] b);
            int cap;
            cap = fifo_en ? DEF_RX_DEPTH : 1;
            if (rx_cnt >= cap)
            begin
                ovr = 1'b1;
                return 1'b0;
            end
            rx_mem[rx_tail] = b;
            rx_tail++;
            rx_cnt++;
            return 1'b1;
        endfunction

        function logic [3:0] top_cause();
            if (ier[2] && ovr)
                return IID_LINE;
            if (ier[0] && rx_cnt != 0)
                return (!fifo_en || rx_cnt >= trig) ? IID_RXDATA : IID_TIMEO;
            if (ier[1] && thre_pend)
                return IID_THRE;
            if (ier[3] && msr[3:0] != 4'h0)
                return IID_MODEM;
            return IID_NONE;
        endfunction

        // In loopback the modem outputs feed the status inputs; RI only
        // flags its trailing edge.
        function void follow_modem_lines();
            logic [7:0] lines;
            logic [7:0] chg;
            if (!mcr[4])
            begin
                lines = MSR_RESET;
            end
            else
            begin
                lines = {mcr[3], mcr[2], mcr[0], mcr[1], 4'h0};
            end
            chg = lines ^ {msr[7:4], 4'h0};
            if (chg[4]) msr[0] = 1'b1;
            if (chg[5]) msr[1] = 1'b1;
            if (msr[6] && !lines[6]) msr[2] = 1'b1;
            if (chg[7]) msr[3] = 1'b1;
            msr[7:4] = lines[7:4];
        endfunction

        function void note_request(input logic [1:0] k, input logic [2:0] a,
                                   input logic [7:0] d);
            uart_result_t r;
            logic         dlab;
            logic [3:0]   id;
            logic [3:0]   old_ier;
            logic         turning_off;
            r    = '0;
            dlab = lcr[7];
            case (k)
                REQ_READ:
                begin
                    case (a)
                        ADDR_DATA:
                        begin
                            if (dlab)
                            begin
                                r.read_data = dll;
                            end
                            else if (rx_cnt != 0)
                            begin
                                r.read_data = rx_mem[rx_head];
                                rx_head++;
                                rx_cnt--;
                            end
                        end
                        ADDR_IER: r.read_data = dlab ? dlm : {4'h0, ier};
                        ADDR_IIR:
                        begin
                            id = top_cause();
                            if (id == IID_THRE)
                                thre_pend = 1'b0;
                            r.read_data = {4'h0, id} | (fifo_en ? IIR_FIFO : 8'h00);
                        end
                        ADDR_LCR: r.read_data = lcr;
                        ADDR_MCR: r.read_data = {3'b000, mcr};
                        ADDR_LSR:
                        begin
                            r.read_data = LSR_IDLE;
                            r.read_data[0] = (rx_cnt != 0);
                            if (ovr)
                            begin
                                r.read_data[1] = 1'b1;
                                r.read_data[7] = fifo_en;
                            end
                            ovr = 1'b0;
                        end
                        ADDR_MSR:
                        begin
                            r.read_data = msr;
                            msr[3:0] = 4'h0;
                        end
                        default: r.read_data = scr;
                    endcase
                end
                REQ_WRITE:
                begin
                    case (a)
                        ADDR_DATA:
                        begin
                            if (dlab)
                            begin
                                dll = d;
                            end
                            else
                            begin
                                thre_pend = 1'b0;
                                if (mcr[4])
                                begin
                                    r.rx_accepted = rx_push(d);
                                end
                                else
                                begin
                                    r.tx_valid = 1'b1;
                                    r.tx_byte  = d;
                                end
                                if (ier[1])
                                    thre_pend = 1'b1;
                            end
                        end
                        ADDR_IER:
                        begin
                            if (dlab)
                            begin
                                dlm = d;
                            end
                            else
                            begin
                                old_ier = ier;
                                ier = d[3:0];
                                if (!ier[1])
                                    thre_pend = 1'b0;
                                else if (!old_ier[1])
                                    thre_pend = 1'b1;
                            end
                        end
                        ADDR_IIR:
                        begin
                            turning_off = fifo_en && !d[0];
                            fifo_en = d[0];
                            case (d[7:6])
                                2'b01:   trig = TRIG_4;
                                2'b10:   trig = TRIG_8;
                                2'b11:   trig = TRIG_14;
                                default: trig = TRIG_1;
                            endcase
                            if (d[1] || turning_off)
                            begin
                                rx_head = '0;
                                rx_tail = '0;
                                rx_cnt  = '0;
                                ovr     = 1'b0;
                            end
                            if (d[2] && ier[1])
                                thre_pend = 1'b1;
                        end
                        ADDR_LCR: lcr = d;
                        ADDR_MCR:
                        begin
                            mcr = d[4:0];
                            follow_modem_lines();
                        end
                        ADDR_SCR: scr = d;
                        default: ;
                    endcase
                end
                REQ_RXB: r.rx_accepted = rx_push(d);
                default: ;
            endcase
            r.irq_out = (top_cause() != IID_NONE);
            awaited_q.push_back(r);
        endfunction

        task check_result(input uart_result_t got);
            uart_result_t want;
            if (awaited_q.size() == 0)
            begin
                report("result returned with no request outstanding");
                return;
            end
            want = awaited_q.pop_front();
            if (got.read_data !== want.read_data)
                report($sformatf("read_data %0h, predicted %0h",
                                 got.read_data, want.read_data));
            if (got.rx_accepted !== want.rx_accepted)
                report($sformatf("rx_accepted %0b, predicted %0b",
                                 got.rx_accepted, want.rx_accepted));
            if (got.tx_valid !== want.tx_valid)
                report($sformatf("tx_valid %0b, predicted %0b",
                                 got.tx_valid, want.tx_valid));
            if (got.tx_byte !== want.tx_byte)
                report($sformatf("tx_byte %0h, predicted %0h",
                                 got.tx_byte, want.tx_byte));
            if (got.irq_out !== want.irq_out)
                report($sformatf("irq_out %0b, predicted %0b",
                                 got.irq_out, want.irq_out));
        endtask
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [1:0] req_type;
    logic [2:0] reg_addr;
    logic [7:0] data_byte;
    logic       burst_last;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] read_data;
    logic       rx_accepted;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       irq_out;

    uart_scoreboard sb;
    int             items_sent = 0;
    bit             calm = 1'b0;
    int             stall_hold = 0;

    uart_16550_register_model_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .reg_addr    (reg_addr),
        .data_byte   (data_byte),
        .burst_last  (burst_last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_data   (read_data),
        .rx_accepted (rx_accepted),
        .tx_valid    (tx_valid),
        .tx_byte     (tx_byte),
        .irq_out     (irq_out)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result-side back-pressure: short stalls mostly, long ones now and then,
    // and none at all during calm segments.
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1)
        begin
            out_stall <= 1'b0;
        end
        else if (stall_hold > 0)
        begin
            stall_hold = stall_hold - 1;
        end
        else if (calm)
        begin
            out_stall  <= 1'b0;
            stall_hold = 8;
        end
        else if ($urandom_range(0, 99) < 60)
        begin
            out_stall  <= 1'b0;
            stall_hold = $urandom_range(0, 6);
        end
        else
        begin
            out_stall  <= 1'b1;
            stall_hold = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 40)
                                                        : $urandom_range(0, 3);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            sb.check_result({read_data, rx_accepted, tx_valid, tx_byte, irq_out});
        end
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Presents one request and holds it until the block takes it.
    task automatic send(input logic [1:0] k, input logic [2:0] a,
                        input logic [7:0] d, input logic last);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= k;
        reg_addr   <= a;
        data_byte  <= d;
        burst_last <= last;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_request(k, a, d);
        items_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.awaited_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_request();
        logic [1:0] k;
        logic [2:0] a;
        logic [7:0] d;
        int         r;
        r = $urandom_range(0, 99);
        a = 3'($urandom_range(0, 7));
        d = 8'($urandom_range(0, 255));
        if (r < 28)
        begin
            k = REQ_RXB;
        end
        else if (r < 62)
        begin
            k = REQ_READ;
            if ($urandom_range(0, 2) == 0)
                a = ADDR_DATA;
        end
        else if (r < 97)
        begin
            k = REQ_WRITE;
            // Keep DLAB, FIFO resets and loopback from dominating the run.
            if (a == ADDR_LCR && $urandom_range(0, 3) != 0)
                d[7] = 1'b0;
            if (a == ADDR_IIR)
            begin
                if ($urandom_range(0, 3) != 0)
                    d[0] = 1'b1;
                if ($urandom_range(0, 2) != 0)
                    d[1] = 1'b0;
            end
            if (a == ADDR_MCR && $urandom_range(0, 2) != 0)
                d[4] = 1'b0;
        end
        else
        begin
            k = REQ_NONE;
        end
        send(k, a, d, 1'($urandom_range(0, 1)));
    endtask

    // A run of wire bytes followed by a host draining it through RBR, with
    // status polls mixed in.
    task automatic rx_burst();
        int n;
        int m;
        int i;
        n = $urandom_range(1, 20);
        for (i = 0; i < n; i++)
            send(REQ_RXB, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                 i == n - 1);
        m = $urandom_range(0, n + 2);
        for (i = 0; i < m; i++)
        begin
            case ($urandom_range(0, 7))
                0:       send(REQ_READ, ADDR_LSR, 8'($urandom_range(0, 255)), 1'b0);
                1:       send(REQ_READ, ADDR_IIR, 8'($urandom_range(0, 255)), 1'b0);
                default: send(REQ_READ, ADDR_DATA, 8'($urandom_range(0, 255)), 1'b0);
            endcase
        end
    endtask

    initial
    begin
        int next_mark;
        sb         = new();
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        req_type   <= REQ_READ;
        reg_addr   <= ADDR_DATA;
        data_byte  <= 8'h00;
        burst_last <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        send(REQ_READ,  ADDR_IIR,  8'h00, 1'b0);
        send(REQ_READ,  ADDR_LSR,  8'h00, 1'b0);
        send(REQ_READ,  ADDR_MSR,  8'h00, 1'b0);
        send(REQ_WRITE, ADDR_SCR,  8'hFF, 1'b1);
        send(REQ_READ,  ADDR_SCR,  8'h00, 1'b0);
        send(REQ_WRITE, ADDR_LCR,  8'h83, 1'b0);
        send(REQ_WRITE, ADDR_DATA, 8'hFF, 1'b0);
        send(REQ_WRITE, ADDR_IER,  8'hA5, 1'b0);
        send(REQ_READ,  ADDR_DATA, 8'h00, 1'b0);
        send(REQ_READ,  ADDR_IER,  8'h00, 1'b0);
        send(REQ_WRITE, ADDR_LCR,  8'h03, 1'b0);
        send(REQ_WRITE, ADDR_IER,  8'hFF, 1'b0);
        send(REQ_WRITE, ADDR_DATA, 8'h00, 1'b0);
        send(REQ_READ,  ADDR_IIR,  8'h00, 1'b0);
        send(REQ_READ,  ADDR_DATA, 8'h00, 1'b0);
        // Single-byte holding register: the second byte overruns.
        send(REQ_RXB,   ADDR_SCR,  8'hFF, 1'b0);
        send(REQ_RXB,   ADDR_DATA, 8'h55, 1'b1);
        send(REQ_READ,  ADDR_IIR,  8'h00, 1'b0);
        send(REQ_READ,  ADDR_LSR,  8'h00, 1'b0);
        send(REQ_READ,  ADDR_DATA, 8'h00, 1'b0);
        send(REQ_WRITE, ADDR_IIR,  8'hC7, 1'b0);
        send(REQ_RXB,   ADDR_DATA, 8'h81, 1'b1);
        send(REQ_WRITE, ADDR_MCR,  8'hFF, 1'b0);
        send(REQ_READ,  ADDR_MSR,  8'h00, 1'b0);
        send(REQ_WRITE, ADDR_MCR,  8'h10, 1'b0);
        send(REQ_WRITE, ADDR_DATA, 8'h3C, 1'b0);
        send(REQ_WRITE, ADDR_LSR,  8'hFF, 1'b0);
        send(REQ_WRITE, ADDR_MSR,  8'hFF, 1'b0);
        send(REQ_NONE,  ADDR_SCR,  8'hFF, 1'b1);
        send(REQ_WRITE, ADDR_IIR,  8'h00, 1'b0);
        send(REQ_WRITE, ADDR_MCR,  8'h00, 1'b0);
        wait_drained();

        next_mark = items_sent + SEGMENT;
        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent >= next_mark)
            begin
                next_mark = next_mark + SEGMENT;
                calm = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 1) == 0)
                    wait_drained();
            end
            if ($urandom_range(0, 9) == 0)
                rx_burst();
            else
                random_request();
        end

        wait_drained();
        repeat (4) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
